// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// shared types, constants and codes of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int CACHE_ENTRIES = 16;
	localparam int CACHE_IDX_W   = $clog2(CACHE_ENTRIES);
	localparam int POS_W         = CACHE_IDX_W + 1;
	localparam int BLK_W         = 15;
	localparam int MAX_BLOCKS    = 32768;
	localparam int BYTE_W        = 8;
	localparam int BIT_IDX_W     = 3;
	localparam int MAP_BYTES     = MAX_BLOCKS / BYTE_W;
	localparam int MAP_ADDR_W    = $clog2(MAP_BYTES);

	// command codes
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_LOAD  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NONE  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [BLK_W-1:0] block_or_byte;
		logic [7:0]       map_bits;
	} in_word_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [BLK_W-1:0] granted_block;
	} out_word_t;

	// access to the free-block cache
	typedef struct packed {
		logic                   clr;
		logic                   we;
		logic [CACHE_IDX_W-1:0] widx;
		logic [BLK_W-1:0]       wdata;
		logic [CACHE_IDX_W-1:0] ridx;
	} cache_req_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ALLOC_CHK,
		ST_SCAN,
		ST_ALLOC_PICK,
		ST_FREE_CHK,
		ST_INS_WALK,
		ST_BIT_RD,
		ST_BIT_WR,
		ST_DONE
	} bba_state_t;

endpackage

// ===== rtl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// block allocator: used-bit bitmap in ram plus a 16-entry free-block cache
// ----------------------------------------------------------------------------
// One command word is taken at a time and gives exactly one result word.
// After reset the bitmap ram is swept to zero, one byte a cycle; in_ready
// stays low during that pass (total_blocks may be written). An allocate
// served from the cache goes through accept, cache check, pick, bitmap
// read-modify-write and result. A refill clears the cache and scans the
// bitmap upward from the last granted block, reading one bitmap byte at a
// time and collecting its free blocks, bounded by 16 collected blocks or by
// total_blocks. The time a free takes is set by the walk over the cache
// entries to find the insert slot; an out-of-range free, a load and an
// unused command go straight from accept to the result.
// The single bitmap ram port sets the pace of scans and bit updates.
// ----------------------------------------------------------------------------
module bitmap_block_allocator import bba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [BLK_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_data
);

	// control state
	bba_state_t state_q, state_d;
	logic [POS_W-1:0]      pos_q, pos_d;        // next cache entry to hand out
	logic [BLK_W-1:0]      last_q, last_d;      // last granted block
	logic [BLK_W-1:0]      total_q;             // total_blocks register
	logic [MAP_ADDR_W-1:0] clr_q, clr_d;        // clearing pass address
	logic                  out_valid_q, out_valid_d;

	// working registers for the current word
	in_word_t              in_q, in_d;
	logic [BLK_W-1:0]      tgt_q, tgt_d;        // block whose bit gets updated
	logic [MAP_ADDR_W-1:0] scan_addr_q, scan_addr_d;
	logic [BIT_IDX_W-1:0]  scan_bit_q, scan_bit_d;
	logic [POS_W-1:0]      scan_n_q, scan_n_d;  // blocks collected in refill
	logic [BYTE_W-1:0]     byte_q, byte_d;      // bitmap byte under scan
	logic                  fresh_q, fresh_d;    // byte comes from ram this cycle
	logic [POS_W-1:0]      walk_q, walk_d;      // insert walk index
	out_word_t             res_q, res_d;
	out_word_t             out_q, out_d;

	// ram and cache access
	logic                  mem_we;
	logic [MAP_ADDR_W-1:0] mem_addr;
	logic [BYTE_W-1:0]     mem_wdata;
	logic [BYTE_W-1:0]     mem_rdata;
	cache_req_t            creq;
	logic [BLK_W-1:0]      cache_rdata;

	// scan helpers
	logic [BYTE_W-1:0]     scan_byte;
	logic [BYTE_W-1:0]     cand;
	logic                  cand_any;
	logic [BIT_IDX_W-1:0]  cand_idx;
	logic [BLK_W:0]        next_start;
	logic [MAP_ADDR_W-1:0] lim_addr;
	logic [BIT_IDX_W-1:0]  lim_bit;
	logic [BYTE_W-1:0]     bit_mask;
	logic [POS_W-1:0]      pos_dec;

	bba_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAP_BYTES)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	bba_cache u_cache (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (creq),
		.rdata (cache_rdata)
	);

	// free bits of the byte under scan that lie at or above the start bit and
	// below total_blocks
	assign scan_byte = fresh_q ? mem_rdata : byte_q;
	assign lim_addr  = total_q[BLK_W-1:BIT_IDX_W];
	assign lim_bit   = total_q[BIT_IDX_W-1:0];

	always_comb begin
		for (int i = 0; i < BYTE_W; i++) begin
			cand[i] = !scan_byte[i] && (BIT_IDX_W'(i) >= scan_bit_q) &&
				((scan_addr_q < lim_addr) ||
				 ((scan_addr_q == lim_addr) && (BIT_IDX_W'(i) < lim_bit)));
		end
		cand_idx = '0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			if (cand[i]) begin
				cand_idx = BIT_IDX_W'(i);
			end
		end
	end

	assign cand_any   = |cand;
	assign next_start = {1'b0, scan_addr_q, {BIT_IDX_W{1'b0}}} + (BLK_W+1)'(BYTE_W);
	assign bit_mask   = BYTE_W'(1) << tgt_q[BIT_IDX_W-1:0];
	assign pos_dec    = pos_q - POS_W'(1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			last_q      <= '0;
			total_q     <= BLK_W'(MAX_BLOCKS - 1);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pos_q       <= pos_d;
			last_q      <= last_d;
			clr_q       <= clr_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		in_q        <= in_d;
		tgt_q       <= tgt_d;
		scan_addr_q <= scan_addr_d;
		scan_bit_q  <= scan_bit_d;
		scan_n_q    <= scan_n_d;
		byte_q      <= byte_d;
		fresh_q     <= fresh_d;
		walk_q      <= walk_d;
		res_q       <= res_d;
		out_q       <= out_d;
	end

	// next state and datapath control
	always_comb begin
		state_d     = state_q;
		pos_d       = pos_q;
		last_d      = last_q;
		clr_d       = clr_q;
		out_valid_d = out_valid_q && !out_ready;
		in_d        = in_q;
		tgt_d       = tgt_q;
		scan_addr_d = scan_addr_q;
		scan_bit_d  = scan_bit_q;
		scan_n_d    = scan_n_q;
		byte_d      = byte_q;
		fresh_d     = fresh_q;
		walk_d      = walk_q;
		res_d       = res_q;
		out_d       = out_q;
		mem_we      = 1'b0;
		mem_addr    = '0;
		mem_wdata   = '0;
		creq        = '0;
		in_ready    = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				// zero the bitmap one byte a cycle
				mem_we   = 1'b1;
				mem_addr = clr_q;
				clr_d    = clr_q + MAP_ADDR_W'(1);
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end

			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					in_d  = in_data;
					tgt_d = in_data.block_or_byte;
					res_d = '{status: STAT_OK, granted_block: '0};
					case (in_data.cmd)
						CMD_ALLOC: begin
							state_d = ST_ALLOC_CHK;
						end
						CMD_FREE: begin
							if ((in_data.block_or_byte == '0) ||
							    (in_data.block_or_byte >= total_q)) begin
								res_d.status = STAT_RANGE;
								state_d      = ST_DONE;
							end else begin
								state_d = ST_FREE_CHK;
							end
						end
						CMD_LOAD: begin
							// byte load goes straight into the ram when the byte address is in range
							if (in_data.block_or_byte[BLK_W-1:MAP_ADDR_W] != '0) begin
								res_d.status = STAT_RANGE;
							end else begin
								mem_we    = 1'b1;
								mem_addr  = in_data.block_or_byte[MAP_ADDR_W-1:0];
								mem_wdata = in_data.map_bits;
							end
							state_d = ST_DONE;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end

			ST_ALLOC_CHK: begin
				creq.ridx = pos_q[CACHE_IDX_W-1:0];
				if (pos_q[POS_W-1] || (cache_rdata == '0)) begin
					// refill: clear cache, start scan at last granted block if below total_blocks
					creq.clr    = 1'b1;
					pos_d       = '0;
					scan_n_d    = '0;
					scan_addr_d = last_q[BLK_W-1:BIT_IDX_W];
					scan_bit_d  = last_q[BIT_IDX_W-1:0];
					fresh_d     = 1'b1;
					mem_addr    = last_q[BLK_W-1:BIT_IDX_W];
					if (last_q < total_q) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_ALLOC_PICK;
					end
				end else begin
					state_d = ST_ALLOC_PICK;
				end
			end

			ST_SCAN: begin
				if (cand_any) begin
					creq.we    = 1'b1;
					creq.widx  = scan_n_q[CACHE_IDX_W-1:0];
					creq.wdata = {scan_addr_q, cand_idx};
					scan_n_d   = scan_n_q + POS_W'(1);
					byte_d     = scan_byte | (BYTE_W'(1) << cand_idx);
					fresh_d    = 1'b0;
					if (scan_n_q == POS_W'(CACHE_ENTRIES - 1)) begin
						state_d = ST_ALLOC_PICK;
					end
				end else if (next_start < {1'b0, total_q}) begin
					// nothing left in this byte, fetch the next one
					scan_addr_d = scan_addr_q + MAP_ADDR_W'(1);
					scan_bit_d  = '0;
					fresh_d     = 1'b1;
					mem_addr    = scan_addr_q + MAP_ADDR_W'(1);
				end else begin
					state_d = ST_ALLOC_PICK;
				end
			end

			ST_ALLOC_PICK: begin
				creq.ridx = pos_q[CACHE_IDX_W-1:0];
				if (cache_rdata == '0) begin
					res_d.status = STAT_NONE;
					state_d      = ST_DONE;
				end else begin
					pos_d               = pos_q + POS_W'(1);
					last_d              = cache_rdata;
					tgt_d               = cache_rdata;
					res_d.granted_block = cache_rdata;
					mem_addr            = cache_rdata[BLK_W-1:BIT_IDX_W];
					state_d             = ST_BIT_WR;
				end
			end

			ST_FREE_CHK: begin
				creq.ridx = pos_q[CACHE_IDX_W-1:0];
				if (pos_q[POS_W-1]) begin
					// cache used up: overwrite the last entry
					pos_d      = POS_W'(CACHE_ENTRIES - 1);
					creq.we    = 1'b1;
					creq.widx  = CACHE_IDX_W'(CACHE_ENTRIES - 1);
					creq.wdata = tgt_q;
					state_d    = ST_BIT_RD;
				end else if (pos_q != '0) begin
					if (cache_rdata > tgt_q) begin
						pos_d      = pos_dec;
						creq.we    = 1'b1;
						creq.widx  = pos_dec[CACHE_IDX_W-1:0];
						creq.wdata = tgt_q;
						state_d    = ST_BIT_RD;
					end else begin
						walk_d  = pos_q + POS_W'(1);
						state_d = ST_INS_WALK;
					end
				end else begin
					walk_d  = '0;
					state_d = ST_INS_WALK;
				end
			end

			ST_INS_WALK: begin
				// first entry that is empty or above the freed block
				creq.ridx = walk_q[CACHE_IDX_W-1:0];
				if (walk_q[POS_W-1]) begin
					state_d = ST_BIT_RD;
				end else if ((cache_rdata > tgt_q) || (cache_rdata == '0)) begin
					creq.we    = 1'b1;
					creq.widx  = walk_q[CACHE_IDX_W-1:0];
					creq.wdata = tgt_q;
					state_d    = ST_BIT_RD;
				end else begin
					walk_d = walk_q + POS_W'(1);
				end
			end

			ST_BIT_RD: begin
				mem_addr = tgt_q[BLK_W-1:BIT_IDX_W];
				state_d  = ST_BIT_WR;
			end

			ST_BIT_WR: begin
				// set the bit on allocate, clear it on free
				mem_we   = 1'b1;
				mem_addr = tgt_q[BLK_W-1:BIT_IDX_W];
				if (in_q.cmd == CMD_ALLOC) begin
					mem_wdata = mem_rdata | bit_mask;
				end else begin
					mem_wdata = mem_rdata & ~bit_mask;
				end
				state_d = ST_DONE;
			end

			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_d       = res_q;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// generic single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== rtl/bba_cache.sv =====
// ----------------------------------------------------------------------------
// bba_cache
// small register file of cached free block numbers, one read, one write
// ----------------------------------------------------------------------------
module bba_cache import bba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cache_req_t       req,
	output logic [BLK_W-1:0] rdata
);

	logic [BLK_W-1:0] entry_q [CACHE_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				entry_q[i] <= '0;
			end
		end else if (req.clr) begin
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				entry_q[i] <= '0;
			end
		end else if (req.we) begin
			entry_q[req.widx] <= req.wdata;
		end
	end

	assign rdata = entry_q[req.ridx];

endmodule

// ===== rtl/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker
// port-level checks of the bitmap block allocator, bound to the top level
// ----------------------------------------------------------------------------
module bba_checker import bba_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	// failed words (status other than ok) grant nothing
	a_no_grant_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != STAT_OK) |-> out_data.granted_block == '0)
		else $error("granted block on non-ok status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == STAT_OK) || (out_data.status == STAT_NONE) ||
			(out_data.status == STAT_RANGE))
		else $error("undefined status code");

	// one command word in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word dropped or changed while stalled");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
